/* src/sfcc_pkg.sv */
`default_nettype none

package sfcc_pkg;

  // frame kinds
  localparam logic [1:0] FUNC_TEMP   = 2'd0;
  localparam logic [1:0] FUNC_HUM    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  // register map, word index = paddr[3:2]
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_TEMP_CMD   = 2'd0;
  localparam logic [1:0] REG_HUM_CMD    = 2'd1;
  localparam logic [1:0] REG_STATUS_CMD = 2'd2;

  localparam logic [7:0] TEMP_CMD_RESET   = 8'd3;
  localparam logic [7:0] HUM_CMD_RESET    = 8'd5;
  localparam logic [7:0] STATUS_CMD_RESET = 8'd7;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // temperature: x = raw - 3970, u = x + 25*1470 >= 0, q = u/25 via reciprocal
  localparam logic [16:0] TEMP_U_OFFSET = 17'd32780;
  localparam logic [17:0] TEMP_RECIP    = 18'd167773;   // ceil(2^22 / 25)
  localparam int unsigned TEMP_RECIP_SH = 22;
  localparam logic [16:0] TEMP_DIV      = 17'd25;
  localparam logic [31:0] TEMP_Q_BIAS   = 32'd1470;

  // humidity: result = round(64*m / 5^9), m = n / 5
  // A = 64*73400000*s - 64*3191*s^2 + bias, bias folds the constant term,
  // the half-step and 2^28 * 5^9 to keep A positive
  localparam logic [27:0] HUM_LIN_K   = 28'd73400000;
  localparam logic [17:0] HUM_SQ_K    = 18'd204224;
  localparam logic [50:0] HUM_BIAS    = 51'd524026010576562;
  localparam logic [31:0] HUM_RECIP   = 32'd2305843009;  // floor(2^52 / 5^9)
  localparam logic [20:0] HUM_DEN     = 21'd1953125;
  localparam logic [22:0] HUM_DEN_X2  = 23'd3906250;
  localparam logic [31:0] HUM_Q_BIAS  = 32'd268435456;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] check_byte;
  } frame_t;

  typedef struct packed {
    logic               crc_ok;
    logic signed [15:0] raw_value;
    logic signed [31:0] measured_value;
  } result_t;

endpackage

`default_nettype wire

/* src/sensor_frame_crc_check_convert.sv */
`default_nettype none

// channel   dir  payload    handshake
// frame     in   frame_t    frame_valid / frame_stall
// result    out  result_t   result_valid / result_stall
// config    in   APB        psel penable pwrite paddr pwdata prdata pready
//
// Six register stages, one request per cycle unless result_stall holds the pipeline.
// The humidity path sets the depth: polynomial, reciprocal multiply,
// back-multiply for the remainder, then the final correction.
// Synchronous reset clears the valid bits and loads the default commands.
// Each stage holds while the one after it is full and stalled; bubbles close up.
module sensor_frame_crc_check_convert
  import sfcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  frame_valid,
  output      logic                  frame_stall,
  input  wire frame_t                frame,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      result_t               result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // round(r * 16384 / 25)
  function automatic logic [13:0] temp_frac(input logic [4:0] r);
    logic [13:0] f;
    case (r)
      5'd0:    f = 14'd0;
      5'd1:    f = 14'd655;
      5'd2:    f = 14'd1311;
      5'd3:    f = 14'd1966;
      5'd4:    f = 14'd2621;
      5'd5:    f = 14'd3277;
      5'd6:    f = 14'd3932;
      5'd7:    f = 14'd4588;
      5'd8:    f = 14'd5243;
      5'd9:    f = 14'd5898;
      5'd10:   f = 14'd6554;
      5'd11:   f = 14'd7209;
      5'd12:   f = 14'd7864;
      5'd13:   f = 14'd8520;
      5'd14:   f = 14'd9175;
      5'd15:   f = 14'd9830;
      5'd16:   f = 14'd10486;
      5'd17:   f = 14'd11141;
      5'd18:   f = 14'd11796;
      5'd19:   f = 14'd12452;
      5'd20:   f = 14'd13107;
      5'd21:   f = 14'd13763;
      5'd22:   f = 14'd14418;
      5'd23:   f = 14'd15073;
      5'd24:   f = 14'd15729;
      default: f = 14'd0;
    endcase
    return f;
  endfunction

  // ---------------- configuration ----------------
  logic [7:0] temp_cmd;
  logic [7:0] hum_cmd;
  logic [7:0] status_cmd;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cmd   <= TEMP_CMD_RESET;
      hum_cmd    <= HUM_CMD_RESET;
      status_cmd <= STATUS_CMD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_TEMP_CMD:   temp_cmd   <= pwdata[7:0];
        REG_HUM_CMD:    hum_cmd    <= pwdata[7:0];
        REG_STATUS_CMD: status_cmd <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TEMP_CMD:   prdata = {24'd0, temp_cmd};
      REG_HUM_CMD:    prdata = {24'd0, hum_cmd};
      REG_STATUS_CMD: prdata = {24'd0, status_cmd};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline flow ----------------
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6 || !result_stall;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign frame_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= frame_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // ---------------- stage 1: decode, CRC over command ----------------
  logic [1:0]         func1;
  logic [7:0]         b0_1, b1_1, chk1, crc1;
  logic signed [15:0] raw1;
  logic [16:0]        u1;
  logic [7:0]         cmd_sel;
  logic signed [15:0] raw_sel;

  always_comb begin
    case (frame.func)
      FUNC_TEMP: begin
        cmd_sel = temp_cmd;
        raw_sel = {frame.first_byte, frame.second_byte};
      end
      FUNC_HUM: begin
        cmd_sel = hum_cmd;
        raw_sel = {frame.first_byte, frame.second_byte};
      end
      FUNC_STATUS: begin
        cmd_sel = status_cmd;
        raw_sel = {8'd0, frame.first_byte};
      end
      default: begin
        cmd_sel = 8'd0;
        raw_sel = 16'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      func1 <= frame.func;
      b0_1  <= frame.first_byte;
      b1_1  <= frame.second_byte;
      chk1  <= frame.check_byte;
      crc1  <= crc8_byte(8'd0, cmd_sel);
      raw1  <= raw_sel;
      u1    <= 17'(raw_sel) + TEMP_U_OFFSET;
    end
  end

  // ---------------- stage 2: CRC first byte, products ----------------
  logic [1:0]         func2;
  logic [7:0]         b1_2, chk2, crc2;
  logic signed [15:0] raw2;
  logic [30:0]        sq2;
  logic signed [43:0] lin2;
  logic [34:0]        tq2;
  logic [16:0]        u2;
  logic signed [31:0] sq_full;

  assign sq_full = raw1 * raw1;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      func2 <= func1;
      b1_2  <= b1_1;
      chk2  <= chk1;
      crc2  <= crc8_byte(crc1, b0_1);
      raw2  <= raw1;
      sq2   <= sq_full[30:0];
      lin2  <= 44'(raw1) * $signed({16'd0, HUM_LIN_K});
      tq2   <= 35'(u1) * 35'(TEMP_RECIP);
      u2    <= u1;
    end
  end

  // ---------------- stage 3: CRC second byte, polynomial, temp quotient ----------------
  logic [1:0]         func3;
  logic [7:0]         chk3, crc3;
  logic signed [15:0] raw3;
  logic [48:0]        acc3;
  logic [11:0]        qt3;
  logic [4:0]         rt3;
  logic [11:0]        qt_c;
  logic [16:0]        qt_back;
  logic [16:0]        rt_wide;
  logic [50:0]        sq_term;
  logic [50:0]        hum_acc;

  assign qt_c    = tq2[TEMP_RECIP_SH+11:TEMP_RECIP_SH];
  assign qt_back = 17'(qt_c) * TEMP_DIV;
  assign rt_wide = u2 - qt_back;
  assign sq_term = 51'(sq2) * 51'(HUM_SQ_K);
  assign hum_acc = (51'(lin2) << 6) - sq_term + HUM_BIAS;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      func3 <= func2;
      chk3  <= chk2;
      crc3  <= (func2 == FUNC_STATUS) ? crc2 : crc8_byte(crc2, b1_2);
      raw3  <= raw2;
      acc3  <= hum_acc[48:0];
      qt3   <= qt_c;
      rt3   <= rt_wide[4:0];
    end
  end

  // ---------------- stage 4: CRC compare, temp result, reciprocal ----------------
  logic [1:0]         func4;
  logic               ok4;
  logic signed [15:0] raw4;
  logic [48:0]        acc4;
  logic [60:0]        prod4;
  logic [31:0]        tmeas4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      func4  <= func3;
      ok4    <= (rev8(crc3) == chk3);
      raw4   <= raw3;
      acc4   <= acc3;
      prod4  <= 61'(acc3[48:20]) * 61'(HUM_RECIP);
      tmeas4 <= ((32'(qt3) - TEMP_Q_BIAS) << 14) + 32'(temp_frac(rt3));
    end
  end

  // ---------------- stage 5: quotient estimate and remainder ----------------
  logic [1:0]         func5;
  logic               ok5;
  logic signed [15:0] raw5;
  logic [28:0]        qe5;
  logic [22:0]        rem5;
  logic [31:0]        tmeas5;
  logic [28:0]        qe_c;
  logic [48:0]        qd;
  logic [48:0]        rem_wide;

  assign qe_c     = prod4[60:32];
  assign qd       = 49'(qe_c) * 49'(HUM_DEN);
  assign rem_wide = acc4 - qd;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      func5  <= func4;
      ok5    <= ok4;
      raw5   <= raw4;
      qe5    <= qe_c;
      rem5   <= rem_wide[22:0];
      tmeas5 <= tmeas4;
    end
  end

  // ---------------- stage 6: correction, result register ----------------
  logic [28:0] q_fix;
  result_t     res_next;

  always_comb begin
    if (rem5 >= HUM_DEN_X2) begin
      q_fix = qe5 + 29'd2;
    end else if (rem5 >= 23'(HUM_DEN)) begin
      q_fix = qe5 + 29'd1;
    end else begin
      q_fix = qe5;
    end
  end

  always_comb begin
    res_next.crc_ok    = ok5;
    res_next.raw_value = raw5;
    case (func5)
      FUNC_TEMP:   res_next.measured_value = tmeas5;
      FUNC_HUM:    res_next.measured_value = 32'(q_fix) - HUM_Q_BIAS;
      FUNC_STATUS: res_next.measured_value = 32'sd0;
      default: begin
        res_next.crc_ok         = 1'b0;
        res_next.raw_value      = 16'sd0;
        res_next.measured_value = 32'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      result <= res_next;
    end
  end

  assign result_valid = v6;

endmodule

`default_nettype wire
